/* rtl/lirc_pkg.sv */
// lirc_pkg: shared constants and controller/datapath interface types
// for the linear interpolation rate converter; no dependencies
package lirc_pkg;

   // field and register widths
   localparam int SAMPLE_W      = 16;
   localparam int CSR_DATA_W    = 48;
   localparam int CSR_INDEX_W   = 2;
   localparam int CHAN_CNT_W    = 2;
   localparam int STEP_INT_W    = 12;
   localparam int SKIP_W        = 13;
   localparam int RUN_CNT_W     = 6;

   // default arithmetic precision
   localparam int FRACTION_BITS_DEF = 48;
   localparam int WEIGHT_BITS_DEF   = 16;

   // most interpolated outputs per frame
   localparam logic [RUN_CNT_W-1:0] RUN_MAX = 6'd63;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_INT      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_FRAC     = 2'd2;

   // register reset values
   localparam logic [CHAN_CNT_W-1:0] CHAN_CNT_RST = 2'd2;
   localparam logic [STEP_INT_W-1:0] STEP_INT_RST = 12'd1;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;       // latch the incoming frame
      logic mix_emit;      // load an interpolated output and advance position
      logic mix_lor;       // last_of_run flag for that output
      logic last_emit;     // load the final output and clear state
      logic finish_run;    // close a frame that had a previous one
      logic finish_first;  // store the first frame of a stream
   } lirc_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic have_prev;
      logic skip_zero;
      logic adv_skip_zero; // skip distance after the next advance is zero
      logic last_frame;
      logic out_free;      // output register can take a value this cycle
   } lirc_status_type;

endpackage

/* rtl/lirc_ctrl.sv */
// lirc_ctrl: sequencing state machine of the rate converter
// depends on lirc_pkg for command and status types
module lirc_ctrl
   import lirc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  lirc_status_type status,
   output lirc_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_GEN  = 2'd1;
   localparam logic [1:0] ST_LAST = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [RUN_CNT_W-1:0] run_cnt_ff, run_cnt_in;

   // input side is open only between frames
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      run_cnt_in = run_cnt_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               run_cnt_in  = '0;
               state_in    = ST_GEN;
            end
         end
         ST_GEN: begin
            if (!status.have_prev) begin
               cmd.finish_first = 1'b1;
               state_in         = status.last_frame ? ST_LAST : ST_IDLE;
            end else if (status.skip_zero && (run_cnt_ff != RUN_MAX)) begin
               if (status.out_free) begin
                  cmd.mix_emit = 1'b1;
                  cmd.mix_lor  = !status.last_frame &&
                                 (!status.adv_skip_zero || (run_cnt_ff == RUN_MAX - 6'd1));
                  run_cnt_in   = run_cnt_ff + 6'd1;
               end
            end else begin
               cmd.finish_run = 1'b1;
               state_in       = status.last_frame ? ST_LAST : ST_IDLE;
            end
         end
         ST_LAST: begin
            if (status.out_free) begin
               cmd.last_emit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         run_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         run_cnt_ff <= run_cnt_in;
      end
   end

   // at most one state-changing command per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.mix_emit, cmd.last_emit, cmd.finish_run, cmd.finish_first}))
      else $error("lirc_ctrl: conflicting commands");

   // a run never goes past its output limit
   assert property (@(posedge clock) disable iff (reset)
      cmd.mix_emit |-> (run_cnt_ff != RUN_MAX))
      else $error("lirc_ctrl: too many outputs for one frame");

   // the final output is always followed by idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.last_emit |=> (state_ff == ST_IDLE))
      else $error("lirc_ctrl: no return to idle after final output");

endmodule

/* rtl/lirc_datapath.sv */
// lirc_datapath: config registers, frame and phase state, interpolation
// multipliers and output register; depends on lirc_pkg
module lirc_datapath
   import lirc_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   input  logic signed [SAMPLE_W-1:0]   req_sample_a,
   input  logic signed [SAMPLE_W-1:0]   req_sample_b,
   input  logic                         req_last_frame,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SAMPLE_W-1:0]   rsp_out_a,
   output logic signed [SAMPLE_W-1:0]   rsp_out_b,
   output logic                         rsp_last_of_run,
   output logic                         rsp_stream_end,
   input  lirc_cmd_type                 cmd,
   output lirc_status_type              status
);

   localparam int FB = FRACTION_BITS;
   localparam int WB = WEIGHT_BITS;
   localparam int MW = WB + 18;
   // smallest fraction step, ceil(2^FB / 63)
   localparam logic [63:0]   MinFracFull = ((64'd1 << FB) + 64'd62) / 64'd63;
   localparam logic [FB-1:0] MinFrac     = MinFracFull[FB-1:0];

   // config registers
   logic [CHAN_CNT_W-1:0] chan_cnt_ff;
   logic [STEP_INT_W-1:0] step_int_ff;
   logic [CSR_DATA_W-1:0] step_frac_ff;

   // frame and position state
   logic signed [SAMPLE_W-1:0] prev_a_ff, prev_b_ff, cur_a_ff, cur_b_ff;
   logic                       have_prev_ff, last_ff;
   logic [SKIP_W-1:0]          skip_ff;
   logic [FB-1:0]              phase_ff;

   // output register
   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_a_ff, out_b_ff;
   logic                       out_lor_ff, out_end_ff;

   logic                       stereo;
   logic [FB+CSR_DATA_W-1:0]   frac_ext;
   logic [FB-1:0]              frac_raw, frac_inc;
   logic [FB:0]                phase_sum;
   logic [SKIP_W-1:0]          skip_adv;
   logic [WB-1:0]              weight;
   logic signed [SAMPLE_W:0]   diff_a, diff_b;
   logic signed [MW-1:0]       prod_a, prod_b, sum_a, sum_b;
   logic signed [SAMPLE_W-1:0] mix_a, mix_b;
   logic                       out_free;

   assign stereo = chan_cnt_ff[1];

   // config writes, unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cnt_ff  <= CHAN_CNT_RST;
         step_int_ff  <= STEP_INT_RST;
         step_frac_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CHANNEL_COUNT: chan_cnt_ff  <= csr_wdata[CHAN_CNT_W-1:0];
            CSR_STEP_INT:      step_int_ff  <= csr_wdata[STEP_INT_W-1:0];
            CSR_STEP_FRAC:     step_frac_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // position increment with the minimum enforced
   assign frac_ext = {{FB{1'b0}}, step_frac_ff};
   assign frac_raw = frac_ext[FB-1:0];
   assign frac_inc = ((step_int_ff == '0) && (frac_raw < MinFrac)) ? MinFrac : frac_raw;
   assign phase_sum = {1'b0, phase_ff} + {1'b0, frac_inc};
   assign skip_adv  = {1'b0, step_int_ff} + {{(SKIP_W-1){1'b0}}, phase_sum[FB]};

   // interpolation prev + (cur - prev) * w, floored by the arithmetic shift
   assign weight = phase_ff[FB-1 -: WB];
   assign diff_a = $signed({cur_a_ff[SAMPLE_W-1], cur_a_ff})
                 - $signed({prev_a_ff[SAMPLE_W-1], prev_a_ff});
   assign diff_b = $signed({cur_b_ff[SAMPLE_W-1], cur_b_ff})
                 - $signed({prev_b_ff[SAMPLE_W-1], prev_b_ff});
   assign prod_a = diff_a * $signed({1'b0, weight});
   assign prod_b = diff_b * $signed({1'b0, weight});
   assign sum_a  = $signed({{2{prev_a_ff[SAMPLE_W-1]}}, prev_a_ff, {WB{1'b0}}}) + prod_a;
   assign sum_b  = $signed({{2{prev_b_ff[SAMPLE_W-1]}}, prev_b_ff, {WB{1'b0}}}) + prod_b;
   assign mix_a  = sum_a[WB +: SAMPLE_W];
   assign mix_b  = sum_b[WB +: SAMPLE_W];

   // frame capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_a_ff <= req_sample_a;
         cur_b_ff <= req_sample_b;
         last_ff  <= req_last_frame;
      end
   end

   // stream state
   always_ff @(posedge clock) begin
      if (reset || cmd.last_emit) begin
         prev_a_ff    <= '0;
         prev_b_ff    <= '0;
         have_prev_ff <= 1'b0;
         skip_ff      <= '0;
         phase_ff     <= '0;
      end else if (cmd.mix_emit) begin
         phase_ff <= phase_sum[FB-1:0];
         skip_ff  <= skip_adv;
      end else if (cmd.finish_run) begin
         skip_ff      <= skip_ff - {{(SKIP_W-1){1'b0}}, 1'b1};
         prev_a_ff    <= cur_a_ff;
         prev_b_ff    <= cur_b_ff;
         have_prev_ff <= 1'b1;
      end else if (cmd.finish_first) begin
         skip_ff      <= '0;
         phase_ff     <= '0;
         prev_a_ff    <= cur_a_ff;
         prev_b_ff    <= cur_b_ff;
         have_prev_ff <= 1'b1;
      end
   end

   // output register, refilled in the cycle the old value is taken
   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.mix_emit || cmd.last_emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mix_emit) begin
         out_a_ff   <= mix_a;
         out_b_ff   <= stereo ? mix_b : '0;
         out_lor_ff <= cmd.mix_lor;
         out_end_ff <= 1'b0;
      end else if (cmd.last_emit) begin
         out_a_ff   <= cur_a_ff;
         out_b_ff   <= stereo ? cur_b_ff : '0;
         out_lor_ff <= 1'b1;
         out_end_ff <= 1'b1;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_a       = out_a_ff;
   assign rsp_out_b       = out_b_ff;
   assign rsp_last_of_run = out_lor_ff;
   assign rsp_stream_end  = out_end_ff;

   // status to controller
   always_comb begin
      status.have_prev     = have_prev_ff;
      status.skip_zero     = (skip_ff == '0);
      status.adv_skip_zero = (skip_adv == '0);
      status.last_frame    = last_ff;
      status.out_free      = out_free;
   end

   // a waiting output is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !(cmd.mix_emit || cmd.last_emit))
      else $error("lirc_datapath: output overwritten while stalled");

   // the final output leaves the stream cleared
   assert property (@(posedge clock) disable iff (reset)
      cmd.last_emit |=> (!have_prev_ff && (skip_ff == '0) && (phase_ff == '0)))
      else $error("lirc_datapath: state not cleared after stream end");

   // an interpolated output is only made with a previous frame in place
   assert property (@(posedge clock) disable iff (reset)
      cmd.mix_emit |-> (have_prev_ff && (skip_ff == '0)))
      else $error("lirc_datapath: interpolation without a due position");

endmodule

/* rtl/linear_interp_rate_converter.sv */
// Flow: a frame transfer is captured, then the generate state loads each interpolated result
//   into the output register; for a last frame the last state then loads the final result.
// Sequencing: a new frame is taken only in idle; up to 63 interpolated outputs per frame plus
//   a final one for a last frame, one per cycle unless stalled, on a shared multiplier pair.
// Reset (synchronous): registers go to stereo, step 1.0, stream state cleared.
// top level: joins the controller and the datapath; depends on lirc_pkg,
// lirc_ctrl and lirc_datapath
module linear_interp_rate_converter
   import lirc_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_a,
   input  logic signed [SAMPLE_W-1:0] req_sample_b,
   input  logic                       req_last_frame,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_out_a,
   output logic signed [SAMPLE_W-1:0] rsp_out_b,
   output logic                       rsp_last_of_run,
   output logic                       rsp_stream_end
);

   lirc_cmd_type    cmd;
   lirc_status_type status;

   // sequencer
   lirc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and storage
   lirc_datapath #(
      .FRACTION_BITS (FRACTION_BITS),
      .WEIGHT_BITS   (WEIGHT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_sample_a    (req_sample_a),
      .req_sample_b    (req_sample_b),
      .req_last_frame  (req_last_frame),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_a       (rsp_out_a),
      .rsp_out_b       (rsp_out_b),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_stream_end  (rsp_stream_end),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
